FILE: hdl/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types and codes for the next-fit slot allocator: the command and
// result payloads, status codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic REG_POOL_ENABLE = 1'b0;
    localparam logic REG_POOL_SIZE   = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int SIZE_W      = 7;
    localparam int REQ_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 3;

    // Largest slot index a 7-bit size or request can reach, plus one
    localparam int SLOT_LIMIT = 128;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_FULL      = 3'd1,
        ST_FREED     = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_NO_POOL   = 3'd4
    } t_status;

    // Command item
    typedef struct packed {
        logic             command;
        logic [REQ_W-1:0] free_slot;
    } t_item;

    // Result item
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

FILE: hdl/next_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Fixed-size slot pool with a free bitmap and a next-fit search pointer.
//
// Usage:
//   A command (allocate or free) is taken on a clock edge with start high
//   and busy low. The capture step registers it with its candidate
//   vectors; the pick step, in which no command is taken, runs the two
//   lowest-free-slot encoders, updates the map and pointer and registers
//   the result, shown on o_result and flagged by o_valid for exactly one
//   cycle. The result register frees the controller, so busy drops while
//   the result is shown and the next command may be taken in that cycle.
//   The receiver cannot stall; results are not held.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   once; the user issues them only while no command is in flight, which
//   the block does not enforce. Writing pool_size marks every slot free
//   and returns the pointer to zero.
//   Reset: pool disabled, pool_size 64, all slots free, pointer zero, no
//   result pending. There is no clearing pass.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator import nfsa_pkg::*; #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_item                  i_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output t_result                o_result
);

    t_dp_cmd w_cmd;

    // Sequence each transfer
    nfsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Hold pool state and resolve commands
    nfsa_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

FILE: hdl/nfsa_ctrl.sv
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Sequencer for the allocator: takes a command, then runs its pick state in
// which the datapath resolves the search and updates the map.
// ----------------------------------------------------------------------------
module nfsa_ctrl import nfsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PICK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive datapath commands
    always_comb begin
        o_busy        = (r_state == S_PICK);
        o_cmd.capture = (r_state == S_IDLE) && i_start;
        o_cmd.commit  = (r_state == S_PICK);
    end

endmodule

FILE: hdl/nfsa_datapath.sv
// ----------------------------------------------------------------------------
// nfsa_datapath
// Free bitmap, search pointer and configuration registers. On capture it
// registers the command with the masked candidate vectors; on commit an
// allocate takes the first free slot at or after the pointer (else the first
// one) and moves the pointer, a free frees its slot; the result is registered.
// ----------------------------------------------------------------------------
module nfsa_datapath import nfsa_pkg::*; #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_item                  i_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output t_result                o_result
);

    localparam int SLOT_N = (POOL_DEPTH < SLOT_LIMIT) ? POOL_DEPTH : SLOT_LIMIT;
    localparam int IDX_W  = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
    localparam int CMP_W  = 11;

    // Configuration and allocator state
    logic              r_pool_enable;
    logic [SIZE_W-1:0] r_pool_size;
    logic [SLOT_N-1:0] r_free_map;
    logic [SLOT_N-1:0] n_free_map;
    logic [IDX_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  n_ptr;

    // Captured command
    logic              r_command;
    logic [REQ_W-1:0]  r_req;
    logic              r_in_range;
    logic [SLOT_N-1:0] r_hi;
    logic [SLOT_N-1:0] r_all;

    // Result
    logic              r_valid;
    t_result           r_result;
    t_result           n_result;

    // Search terms
    logic [SIZE_W-1:0] w_n;
    logic [SLOT_N-1:0] w_hi;
    logic [SLOT_N-1:0] w_all;
    logic [SLOT_N-1:0] w_hi_low;
    logic [SLOT_N-1:0] w_all_low;
    logic [IDX_W-1:0]  w_hi_idx;
    logic [IDX_W-1:0]  w_all_idx;
    logic [IDX_W-1:0]  w_pick;
    logic [7:0]        w_pick_ext;
    logic [7:0]        w_pick_inc;

    // Clamp the active size to the map depth
    always_comb begin
        if (CMP_W'(r_pool_size) > CMP_W'(POOL_DEPTH)) begin
            w_n = SIZE_W'(POOL_DEPTH);
        end else begin
            w_n = r_pool_size;
        end
    end

    // Mask free slots inside the pool, and those at or after the pointer
    always_comb begin
        for (int j = 0; j < SLOT_N; j++) begin
            w_all[j] = r_free_map[j] && (8'(j) < 8'(w_n));
            w_hi[j]  = w_all[j] && (8'(j) >= 8'(r_ptr));
        end
    end

    // Isolate the lowest set bit of each candidate vector and encode it
    always_comb begin
        w_hi_low  = r_hi & (~r_hi + SLOT_N'(1));
        w_all_low = r_all & (~r_all + SLOT_N'(1));
        w_hi_idx  = '0;
        w_all_idx = '0;
        for (int j = 0; j < SLOT_N; j++) begin
            if (w_hi_low[j]) begin
                w_hi_idx = w_hi_idx | IDX_W'(j);
            end
            if (w_all_low[j]) begin
                w_all_idx = w_all_idx | IDX_W'(j);
            end
        end
        w_pick     = (|r_hi) ? w_hi_idx : w_all_idx;
        w_pick_ext = 8'(w_pick);
        w_pick_inc = w_pick_ext + 8'd1;
    end

    // Resolve the command and the state update
    always_comb begin
        n_free_map      = r_free_map;
        n_ptr           = r_ptr;
        n_result.slot   = '0;
        n_result.status = ST_NO_POOL;
        if (!r_pool_enable) begin
            n_result.status = ST_NO_POOL;
        end else if (r_command == CMD_ALLOC) begin
            if (|r_all) begin
                n_free_map[w_pick] = 1'b0;
                if (w_pick_inc == 8'(w_n)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = w_pick_inc[IDX_W-1:0];
                end
                n_result.slot   = w_pick_ext[SLOT_W-1:0];
                n_result.status = ST_ALLOCATED;
            end else begin
                n_result.status = ST_FULL;
            end
        end else begin
            if (r_in_range) begin
                n_free_map[r_req[IDX_W-1:0]] = 1'b1;
                n_result.slot   = r_req[SLOT_W-1:0];
                n_result.status = ST_FREED;
            end else begin
                n_result.status = ST_OUTSIDE;
            end
        end
    end

    // Capture the command and its candidate vectors
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command  <= i_item.command;
            r_req      <= i_item.free_slot;
            r_in_range <= (i_item.free_slot < w_n);
            r_hi       <= w_hi;
            r_all      <= w_all;
        end
    end

    // Update configuration, map and pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_enable <= 1'b0;
            r_pool_size   <= SIZE_W'(64);
            r_free_map    <= '1;
            r_ptr         <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_POOL_ENABLE) begin
                r_pool_enable <= i_cfg_data[0];
            end else begin
                r_pool_size <= i_cfg_data[SIZE_W-1:0];
                r_free_map  <= '1;
                r_ptr       <= '0;
            end
        end else if (i_cmd.commit) begin
            r_free_map <= n_free_map;
            r_ptr      <= n_ptr;
        end
    end

    // Register the result strobe and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
